// ===== rtl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// Types and constants shared by the pending-acknowledge table.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_CONF   = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_CHINIT = 2'd0;
  localparam logic [1:0] KIND_GW     = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [0:0] CFG_BASE  = 1'd0;
  localparam logic [0:0] CFG_LIMIT = 1'd1;

  localparam logic [15:0] BASE_RESET  = 16'd4;
  localparam logic [15:0] LIMIT_RESET = 16'd600;
  localparam int          MAX_RESULTS = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  msg_kind;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        save_request;
    logic [31:0] next_attempt_seconds;
    logic [4:0]  pending_count;
    logic        entry_valid;
    logic [63:0] entry_id_high;
    logic [63:0] entry_id_low;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/apt_ram.sv =====
// ----------------------------------------------------------------------------
// apt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ack_pending_table_with_backoff.sv =====
// ----------------------------------------------------------------------------
// ack_pending_table_with_backoff
// Table of ids awaiting confirmation with exponential resend backoff.
// ----------------------------------------------------------------------------
//  channel | ports                          | transfer
//  input   | start, busy, in_item           | start && !busy
//  result  | out_strobe, out_item           | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// Every item first scans the key RAM once (one read per address, then a
// decision step), and the result comes in the first idle cycle. A fetch
// listing n ids (at most MAX_RESULTS) runs one further scan and one emit
// step per id, lowest id first, and busy stays high until the last id is out.
// The single RAM read port sets the pace; the receiver cannot stall. Used
// bits sit in flip-flops cleared by reset; keys and kind bits need no clearing.
// ----------------------------------------------------------------------------
module ack_pending_table_with_backoff #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  apt_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output apt_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import apt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DONE = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state_r;
  logic [15:0]            base_r, limit_r, tmo_r;
  logic [31:0]            na_r;
  logic [TABLE_DEPTH-1:0] used_r, gw_r;
  in_item_t               it_r;
  logic [AW:0]            idx_r;      // address issued
  logic                   rv_r;       // read data valid
  logic [AW-1:0]          ridx_r;     // address of read data
  logic                   match_r, free_ok_r, best_ok_r, have_prev_r;
  logic [AW-1:0]          match_idx_r, free_idx_r;
  logic [127:0]           best_key_r, prev_key_r;
  logic [4:0]             listed_r;
  logic [4:0]             list_n_r;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic [127:0]           wkey;
  logic [127:0]           rk;
  logic [CW-1:0]          cnt;
  logic [4:0]             cnt5;
  logic [TABLE_DEPTH-1:0] live, used_ins, used_conf;
  logic                   is_gw_enq, enq_kind_ok, slot_ok, enq_ins;
  logic                   kwe;
  logic [AW-1:0]          kaddr;
  logic [16:0]            dbl;
  logic [15:0]            tmo_fetch;
  logic [31:0]            na_enq, na_fetch;
  logic                   last_pick;
  logic                   key_gt_prev, key_lt_best;

  // key written at the decision step from the latched id
  assign wkey = {it_r.id_high, it_r.id_low};

  apt_ram #(.WIDTH(128), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk  (clk),
    .we   (kwe),
    .waddr(kaddr),
    .wdata(wkey),
    .raddr(idx_r[AW-1:0]),
    .rdata(rk)
  );

  always_comb begin
    cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) cnt = cnt + CW'(used_r[i]);
  end

  assign cnt5 = 5'(cnt);

  // used bits seen by scan: gateway removal applies first for gw enqueue
  assign is_gw_enq   = (it_r.op == OP_ENQ) && (it_r.msg_kind == KIND_GW);
  assign live        = is_gw_enq ? (used_r & ~gw_r) : used_r;
  assign enq_kind_ok = (it_r.op == OP_ENQ) &&
                       (it_r.msg_kind == KIND_CHINIT || it_r.msg_kind == KIND_GW);
  assign slot_ok     = match_r || free_ok_r;
  assign enq_ins     = (state_r == S_DONE) && enq_kind_ok && slot_ok;

  assign kwe   = enq_ins;
  assign kaddr = match_r ? match_idx_r : free_idx_r;

  assign dbl = {tmo_r, 1'b0};

  always_comb begin
    used_ins         = live;
    used_ins[kaddr]  = 1'b1;
    used_conf        = used_r;
    used_conf[match_idx_r] = 1'b0;
    tmo_fetch        = tmo_r;
    if (tmo_r < limit_r) tmo_fetch = dbl[16] ? 16'hFFFF : dbl[15:0];
  end

  assign na_enq    = it_r.now_seconds + {16'd0, base_r};
  assign na_fetch  = it_r.now_seconds + {16'd0, tmo_fetch};
  assign last_pick = (listed_r + 5'd1 == list_n_r);

  assign key_gt_prev = !have_prev_r || (rk > prev_key_r);
  assign key_lt_best = !best_ok_r || (rk < best_key_r);

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_comb begin
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    if (state_r == S_DONE) begin
      out_strobe_nxt                    = 1'b1;
      out_item_nxt                      = '0;
      out_item_nxt.last                 = 1'b1;
      out_item_nxt.next_attempt_seconds = na_r;
      out_item_nxt.pending_count        = cnt5;
      out_item_nxt.status               = ST_REFUSE;
      unique case (it_r.op)
        OP_ENQ: begin
          if (enq_kind_ok) begin
            if (slot_ok) begin
              out_item_nxt.status               = ST_OK;
              out_item_nxt.save_request         = !is_gw_enq;
              out_item_nxt.next_attempt_seconds = na_enq;
              out_item_nxt.pending_count        = 5'($countones(used_ins));
            end else begin
              out_item_nxt.status        = ST_FULL;
              out_item_nxt.pending_count = 5'($countones(live));
            end
          end
        end
        OP_CONF: begin
          if (match_r) begin
            out_item_nxt.status        = ST_OK;
            out_item_nxt.pending_count = 5'($countones(used_conf));
          end
        end
        OP_FETCH: begin
          // empty table gives one bare result, otherwise the listing follows
          out_strobe_nxt                    = (cnt == '0);
          out_item_nxt.status               = ST_OK;
          out_item_nxt.next_attempt_seconds = na_fetch;
        end
        default: ;
      endcase
    end else if (state_r == S_EMIT) begin
      out_strobe_nxt                    = 1'b1;
      out_item_nxt.status               = ST_OK;
      out_item_nxt.save_request         = 1'b0;
      out_item_nxt.next_attempt_seconds = na_r;
      out_item_nxt.pending_count        = cnt5;
      out_item_nxt.entry_valid          = 1'b1;
      out_item_nxt.entry_id_high        = best_key_r[127:64];
      out_item_nxt.entry_id_low         = best_key_r[63:0];
      out_item_nxt.last                 = last_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= BASE_RESET;
      limit_r      <= LIMIT_RESET;
      tmo_r        <= BASE_RESET;
      na_r         <= '0;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
      rv_r         <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      out_item_r   <= out_item_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_LIMIT: limit_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            it_r      <= in_item;
            idx_r     <= '0;
            rv_r      <= 1'b0;
            match_r   <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r < (AW+1)'(TABLE_DEPTH)) begin
            idx_r <= idx_r + 1'b1;
          end
          rv_r   <= idx_r < (AW+1)'(TABLE_DEPTH);
          ridx_r <= idx_r[AW-1:0];
          if (rv_r) begin
            if (live[ridx_r] && rk == wkey && !match_r) begin
              match_r     <= 1'b1;
              match_idx_r <= ridx_r;
            end
            if (!live[ridx_r] && !free_ok_r) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= ridx_r;
            end
            if (ridx_r == AW'(TABLE_DEPTH - 1)) state_r <= S_DONE;
          end
        end
        S_DONE: begin
          unique case (it_r.op)
            OP_ENQ: begin
              state_r <= S_IDLE;
              if (enq_ins) begin
                used_r      <= used_ins;
                gw_r[kaddr] <= is_gw_enq;
                tmo_r       <= base_r;
                na_r        <= na_enq;
              end else if (enq_kind_ok) begin
                used_r <= live;
              end
            end
            OP_CONF: begin
              state_r <= S_IDLE;
              if (match_r) begin
                used_r <= used_conf;
                tmo_r  <= base_r;
              end
            end
            OP_FETCH: begin
              tmo_r <= tmo_fetch;
              na_r  <= na_fetch;
              if (cnt == '0) begin
                state_r <= S_IDLE;
              end else begin
                list_n_r    <= (32'(cnt) > MAX_RESULTS) ? 5'(MAX_RESULTS) : cnt5;
                listed_r    <= '0;
                have_prev_r <= 1'b0;
                idx_r       <= '0;
                rv_r        <= 1'b0;
                best_ok_r   <= 1'b0;
                state_r     <= S_LIST;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_LIST: begin
          if (idx_r < (AW+1)'(TABLE_DEPTH)) idx_r <= idx_r + 1'b1;
          rv_r   <= idx_r < (AW+1)'(TABLE_DEPTH);
          ridx_r <= idx_r[AW-1:0];
          if (rv_r) begin
            if (used_r[ridx_r] && key_gt_prev && key_lt_best) begin
              best_ok_r  <= 1'b1;
              best_key_r <= rk;
            end
            if (ridx_r == AW'(TABLE_DEPTH - 1)) state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          listed_r    <= listed_r + 5'd1;
          prev_key_r  <= best_key_r;
          have_prev_r <= 1'b1;
          best_ok_r   <= 1'b0;
          idx_r       <= '0;
          rv_r        <= 1'b0;
          state_r     <= last_pick ? S_IDLE : S_LIST;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
